// ===== hdl/char_cell_box_draw_engine_assert.svh =====
// Assertion macros shared by the character-cell box draw engine RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef CHAR_CELL_BOX_DRAW_ENGINE_ASSERT_SVH
`define CHAR_CELL_BOX_DRAW_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cbd_pkg.sv =====
// Types, constants and the box character table of the box draw engine.
// No dependencies; imported by cbd_clip and char_cell_box_draw_engine.
package cbd_pkg;

  localparam int ACT_W      = 2;
  localparam int FIELD_W    = 11;
  localparam int GEO_W      = FIELD_W + 2;
  localparam int KIND_W     = 8;
  localparam int SET_W      = 2;
  localparam int STYLE_W    = 32;
  localparam int CP_W       = 21;
  localparam int COLS_REG_W = 8;
  localparam int ROWS_REG_W = 7;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd80;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd24;
  localparam logic [CP_W-1:0]       SPACE_CP   = 21'h000020;

  typedef enum logic [ACT_W-1:0] {
    ACT_DRAW  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_PLAN,
    ST_BASE,
    ST_WALK,
    ST_READ,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    WM_INIT,
    WM_FILL,
    WM_BORDER,
    WM_CLEAR
  } walk_mode_t;

  typedef enum logic [SET_W-1:0] {
    SET_LIGHT  = 2'd0,
    SET_HEAVY  = 2'd1,
    SET_DASHED = 2'd2,
    SET_ROUND  = 2'd3
  } box_set_t;

  typedef enum logic [2:0] {
    PART_HORZ,
    PART_VERT,
    PART_TL,
    PART_TR,
    PART_BL,
    PART_BR
  } part_t;

  // Clipped geometry of one command. The low bounds fx0 and fy0 are non-negative.
  typedef struct packed {
    logic [GEO_W-1:0] fx0;
    logic [GEO_W-1:0] fx_hi;
    logic [GEO_W-1:0] fy0;
    logic [GEO_W-1:0] fy_hi;
    logic [GEO_W-1:0] bx_hi;
    logic [GEO_W-1:0] by_hi;
    logic             area_ok;
    logic             border_ok;
    logic             read_ok;
  } clip_t;

  function automatic logic [CP_W-1:0] box_char(input box_set_t set, input part_t part);
    logic [CP_W-1:0] horz, vert, tl, tr, bl, br;
    horz = 21'h002500;
    vert = 21'h002502;
    tl   = 21'h00250C;
    tr   = 21'h002510;
    bl   = 21'h002514;
    br   = 21'h002518;
    case (set)
      SET_HEAVY: begin
        horz = 21'h002550;
        vert = 21'h002551;
        tl   = 21'h002554;
        tr   = 21'h002557;
        bl   = 21'h00255A;
        br   = 21'h00255D;
      end
      SET_DASHED: begin
        horz = 21'h002504;
        vert = 21'h002506;
      end
      SET_ROUND: begin
        tl = 21'h00256D;
        tr = 21'h00256E;
        bl = 21'h002570;
        br = 21'h00256F;
      end
      default: begin
      end
    endcase
    case (part)
      PART_HORZ: box_char = horz;
      PART_VERT: box_char = vert;
      PART_TL:   box_char = tl;
      PART_TR:   box_char = tr;
      PART_BL:   box_char = bl;
      default:   box_char = br;
    endcase
  endfunction

endpackage

// ===== hdl/cbd_clip.sv =====
// Clips a signed command rectangle to the canvas and checks border and read range.
// Depends on cbd_pkg; instantiated by char_cell_box_draw_engine.
module cbd_clip (
  input  logic signed [cbd_pkg::FIELD_W-1:0] rect_x,
  input  logic signed [cbd_pkg::FIELD_W-1:0] rect_y,
  input  logic        [cbd_pkg::FIELD_W-1:0] rect_w,
  input  logic        [cbd_pkg::FIELD_W-1:0] rect_h,
  input  logic                               border_enable,
  input  logic        [cbd_pkg::GEO_W-1:0]   cols,
  input  logic        [cbd_pkg::GEO_W-1:0]   rows,
  output cbd_pkg::clip_t                     clip
);
  import cbd_pkg::*;

  logic signed [GEO_W-1:0] xs, ys, ws, hs, cs, rs, xe, ye, x0, x1, y0, y1;

  function automatic logic signed [GEO_W-1:0] clamp_geo(input logic signed [GEO_W-1:0] v,
                                                         input logic signed [GEO_W-1:0] hi);
    logic signed [GEO_W-1:0] r;
    r = v;
    if (v[GEO_W-1]) begin
      r = '0;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  always_comb begin
    xs = GEO_W'(rect_x);
    ys = GEO_W'(rect_y);
    ws = $signed(GEO_W'(rect_w));
    hs = $signed(GEO_W'(rect_h));
    cs = $signed(cols);
    rs = $signed(rows);
    xe = xs + ws;
    ye = ys + hs;
    x0 = clamp_geo(xs, cs);
    x1 = clamp_geo(xe, cs);
    y0 = clamp_geo(ys, rs);
    y1 = clamp_geo(ye, rs);

    clip.fx0     = $unsigned(x0);
    clip.fx_hi   = $unsigned(x1 - GEO_W'(1));
    clip.fy0     = $unsigned(y0);
    clip.fy_hi   = $unsigned(y1 - GEO_W'(1));
    clip.bx_hi   = $unsigned(xe - GEO_W'(1));
    clip.by_hi   = $unsigned(ye - GEO_W'(1));
    clip.area_ok = (x1 > x0) && (y1 > y0);
    // The border needs a box of at least two by two that lies wholly on the canvas.
    clip.border_ok = border_enable && (ws >= GEO_W'(2)) && (hs >= GEO_W'(2)) &&
                     !xs[GEO_W-1] && !ys[GEO_W-1] && (xe <= cs) && (ye <= rs) &&
                     clip.area_ok;
    clip.read_ok = !xs[GEO_W-1] && (xs < cs) && !ys[GEO_W-1] && (ys < rs);
  end

endmodule

// ===== hdl/char_cell_box_draw_engine.sv =====
// Character-cell box draw engine: canvas memory, command sequencer and cell walker.
// Depends on cbd_pkg, cbd_clip and char_cell_box_draw_engine_assert.svh.
//
// Usage. Commands arrive on the cmd channel (cmd_valid, cmd_stall) and every
// command gives exactly one response transaction on the rsp channel
// (rsp_valid, rsp_stall). A transaction happens at a rising edge where valid is
// high and stall is low. Commands are draw, read one cell and clear.
// The canvas geometry sits in two APB registers: columns at 0x0, rows at 0x4;
// pready is always high. Change them only while no command is in flight.
// Timing. One command at a time, one cell write per cycle through the memory port.
// A command passes ST_CLIP and ST_PLAN; a read in range, a clear or a draw with work
// then sets its row base in ST_BASE and reads in ST_READ or walks in ST_WALK (fill
// first, then ST_PLAN and ST_BASE again for the border); all end in ST_DONE.
// The next command is taken the cycle after the response is loaded.
// Reset. After rst the engine sweeps all MAX_COLUMNS*MAX_ROWS cells to a space
// with zero style; cmd_stall stays high during the sweep. APB writes are taken at
// any time.
// Stalls. The response sits in an output register. While the receiver stalls,
// the engine still takes a command and works on it; it holds its next response
// until the output register is free again.
module char_cell_box_draw_engine #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  parameter int STYLE_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // Command channel.
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic        [cbd_pkg::ACT_W-1:0]    action,
  input  logic signed [cbd_pkg::FIELD_W-1:0]  rect_x,
  input  logic signed [cbd_pkg::FIELD_W-1:0]  rect_y,
  input  logic        [cbd_pkg::FIELD_W-1:0]  rect_w,
  input  logic        [cbd_pkg::FIELD_W-1:0]  rect_h,
  input  logic                                fill_enable,
  input  logic                                border_enable,
  input  logic        [cbd_pkg::KIND_W-1:0]   border_kind,
  input  logic        [cbd_pkg::STYLE_W-1:0]  style_word,
  // Response channel.
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic        [cbd_pkg::CP_W-1:0]     cell_codepoint,
  output logic        [cbd_pkg::STYLE_W-1:0]  cell_style,
  output logic                                touched,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [cbd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic        [cbd_pkg::APB_DATA_W-1:0] pwdata,
  output logic        [cbd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);
  import cbd_pkg::*;

  localparam int CELLS  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int X_W    = $clog2(MAX_COLUMNS);
  localparam int Y_W    = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int PROD_W = Y_W + COL_W;
  localparam logic [ADDR_W:0] CELLS_LIMIT = (ADDR_W + 1)'(CELLS);

  // ---------------------------------------------------------------------------
  // Configuration registers. The used geometry saturates into the canvas size.
  // ---------------------------------------------------------------------------
  logic [COLS_REG_W-1:0] col_reg;
  logic [ROWS_REG_W-1:0] row_reg;
  logic                  cfg_wr;
  logic [GEO_W-1:0]      cols_c, rows_c;
  logic [COL_W-1:0]      cols;
  logic [ROW_W-1:0]      rows;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_reg <= COLS_RESET;
      row_reg <= ROWS_RESET;
    end else if (cfg_wr) begin
      case (reg_index_t'(paddr[APB_ADDR_W-1]))
        REG_COLUMNS: col_reg <= pwdata[COLS_REG_W-1:0];
        REG_ROWS:    row_reg <= pwdata[ROWS_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[APB_ADDR_W-1]))
      REG_COLUMNS: prdata = APB_DATA_W'(col_reg);
      REG_ROWS:    prdata = APB_DATA_W'(row_reg);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    if (col_reg == '0) begin
      cols_c = GEO_W'(1);
    end else if (GEO_W'(col_reg) > GEO_W'(MAX_COLUMNS)) begin
      cols_c = GEO_W'(MAX_COLUMNS);
    end else begin
      cols_c = GEO_W'(col_reg);
    end
    if (row_reg == '0) begin
      rows_c = GEO_W'(1);
    end else if (GEO_W'(row_reg) > GEO_W'(MAX_ROWS)) begin
      rows_c = GEO_W'(MAX_ROWS);
    end else begin
      rows_c = GEO_W'(row_reg);
    end
  end

  assign cols = COL_W'(cols_c);
  assign rows = ROW_W'(rows_c);

  // ---------------------------------------------------------------------------
  // Command register and clipping.
  // ---------------------------------------------------------------------------
  state_t                      state, state_next;
  logic [ACT_W-1:0]            cmd_act;
  logic signed [FIELD_W-1:0]   cmd_rx, cmd_ry;
  logic [FIELD_W-1:0]          cmd_rw, cmd_rh;
  logic                        cmd_fill, cmd_border;
  logic [SET_W-1:0]            cmd_kind;
  logic [STYLE_BITS-1:0]       cmd_style;
  clip_t                       clip_d, clip_q;

  assign cmd_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      cmd_act    <= action;
      cmd_rx     <= rect_x;
      cmd_ry     <= rect_y;
      cmd_rw     <= rect_w;
      cmd_rh     <= rect_h;
      cmd_fill   <= fill_enable;
      cmd_border <= border_enable;
      cmd_kind   <= border_kind[SET_W-1:0];
      cmd_style  <= STYLE_BITS'(style_word);
    end
    if (state == ST_CLIP) begin
      clip_q <= clip_d;
    end
  end

  cbd_clip u_clip (
    .rect_x        (cmd_rx),
    .rect_y        (cmd_ry),
    .rect_w        (cmd_rw),
    .rect_h        (cmd_rh),
    .border_enable (cmd_border),
    .cols          (cols_c),
    .rows          (rows_c),
    .clip          (clip_d)
  );

  // ---------------------------------------------------------------------------
  // Cell walker. It visits a rectangle row by row; the memory address is the
  // row base plus the column, and the row base advances by the stride. A border
  // walk jumps from the left to the right edge on the middle rows.
  // ---------------------------------------------------------------------------
  walk_mode_t          mode;
  logic [X_W-1:0]      x, x_lo, x_hi;
  logic [Y_W-1:0]      y, y_lo, y_hi;
  logic [ADDR_W-1:0]   row_base;
  logic [COL_W-1:0]    stride;
  logic [PROD_W-1:0]   base_prod;
  logic                fill_done, hit;
  logic                plan_fill, plan_border, plan_clear, plan_read;
  logic                row_first, row_last, col_first, col_last, corner;
  part_t               part;

  logic [ADDR_W-1:0]   mem_addr;
  logic [ADDR_W:0]     mem_addr_ext;
  logic                we_cp, we_st, rd_en, res_load;
  logic [CP_W-1:0]     wr_cp;
  logic [STYLE_BITS-1:0] wr_st;

  assign row_first    = (y == y_lo);
  assign row_last     = (y == y_hi);
  assign col_first    = (x == x_lo);
  assign col_last     = (x == x_hi);
  assign corner       = (row_first || row_last) && (col_first || col_last);
  assign mem_addr     = row_base + ADDR_W'(x);
  assign mem_addr_ext = (ADDR_W + 1)'(mem_addr);
  assign base_prod    = PROD_W'(y) * PROD_W'(stride);

  always_comb begin
    if (corner) begin
      if (row_first) begin
        part = col_first ? PART_TL : PART_TR;
      end else begin
        part = col_first ? PART_BL : PART_BR;
      end
    end else if (row_first || row_last) begin
      part = PART_HORZ;
    end else begin
      part = PART_VERT;
    end
    wr_cp = (mode == WM_BORDER) ? box_char(box_set_t'(cmd_kind), part) : SPACE_CP;
    wr_st = (mode == WM_INIT) ? '0 : cmd_style;
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WALK;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    we_cp       = 1'b0;
    we_st       = 1'b0;
    rd_en       = 1'b0;
    res_load    = 1'b0;
    plan_fill   = 1'b0;
    plan_border = 1'b0;
    plan_clear  = 1'b0;
    plan_read   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_CLIP;
        end
      end
      ST_CLIP: state_next = ST_PLAN;
      ST_PLAN: begin
        case (cmd_act)
          ACT_DRAW: begin
            // Fill goes first; the border is drawn over it afterwards.
            if (clip_q.area_ok && cmd_fill && !fill_done) begin
              plan_fill = 1'b1;
            end else if (clip_q.border_ok) begin
              plan_border = 1'b1;
            end
          end
          ACT_READ:  plan_read  = clip_q.read_ok;
          ACT_CLEAR: plan_clear = 1'b1;
          default: begin
          end
        endcase
        if (plan_fill || plan_border || plan_clear || plan_read) begin
          state_next = ST_BASE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_BASE: state_next = (cmd_act == ACT_READ) ? ST_READ : ST_WALK;
      ST_WALK: begin
        case (mode)
          WM_CLEAR: we_cp = 1'b1;
          WM_BORDER: begin
            // Corners keep the stored style.
            we_cp = 1'b1;
            we_st = !corner;
          end
          default: begin
            we_cp = 1'b1;
            we_st = 1'b1;
          end
        endcase
        if (col_last && row_last) begin
          case (mode)
            WM_INIT: state_next = ST_IDLE;
            WM_FILL: state_next = ST_PLAN;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // Reset starts a sweep over the whole memory.
      mode      <= WM_INIT;
      x         <= '0;
      x_lo      <= '0;
      x_hi      <= X_W'(MAX_COLUMNS - 1);
      y         <= '0;
      y_lo      <= '0;
      y_hi      <= Y_W'(MAX_ROWS - 1);
      row_base  <= '0;
      stride    <= COL_W'(MAX_COLUMNS);
      fill_done <= 1'b0;
      hit       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            fill_done <= 1'b0;
            hit       <= 1'b0;
          end
        end
        ST_PLAN: begin
          stride <= cols;
          if (plan_fill) begin
            mode <= WM_FILL;
            x    <= X_W'(clip_q.fx0);
            x_lo <= X_W'(clip_q.fx0);
            x_hi <= X_W'(clip_q.fx_hi);
            y    <= Y_W'(clip_q.fy0);
            y_lo <= Y_W'(clip_q.fy0);
            y_hi <= Y_W'(clip_q.fy_hi);
            hit  <= 1'b1;
          end
          if (plan_border) begin
            mode <= WM_BORDER;
            x    <= X_W'(cmd_rx);
            x_lo <= X_W'(cmd_rx);
            x_hi <= X_W'(clip_q.bx_hi);
            y    <= Y_W'(cmd_ry);
            y_lo <= Y_W'(cmd_ry);
            y_hi <= Y_W'(clip_q.by_hi);
            hit  <= 1'b1;
          end
          if (plan_clear) begin
            mode <= WM_CLEAR;
            x    <= '0;
            x_lo <= '0;
            x_hi <= X_W'(cols - COL_W'(1));
            y    <= '0;
            y_lo <= '0;
            y_hi <= Y_W'(rows - ROW_W'(1));
          end
          if (plan_read) begin
            x   <= X_W'(cmd_rx);
            y   <= Y_W'(cmd_ry);
            hit <= 1'b1;
          end
        end
        ST_BASE: row_base <= ADDR_W'(base_prod);
        ST_WALK: begin
          if (col_last) begin
            if (!row_last) begin
              y        <= y + Y_W'(1);
              row_base <= row_base + ADDR_W'(stride);
              x        <= x_lo;
            end else if (mode == WM_FILL) begin
              fill_done <= 1'b1;
            end
          end else if (mode == WM_BORDER && !row_first && !row_last) begin
            x <= x_hi;
          end else begin
            x <= x + X_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Canvas memory: codepoints and styles, one shared address, registered read.
  // ---------------------------------------------------------------------------
  logic [CP_W-1:0]       cp_mem [CELLS];
  logic [STYLE_BITS-1:0] st_mem [CELLS];
  logic [CP_W-1:0]       rd_cp;
  logic [STYLE_BITS-1:0] rd_st;

  always_ff @(posedge clk) begin
    if (we_cp) begin
      cp_mem[mem_addr] <= wr_cp;
    end
    if (rd_en) begin
      rd_cp <= cp_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we_st) begin
      st_mem[mem_addr] <= wr_st;
    end
    if (rd_en) begin
      rd_st <= st_mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Response register.
  // ---------------------------------------------------------------------------
  logic read_hit;

  assign read_hit = hit && (cmd_act == ACT_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      cell_codepoint <= read_hit ? rd_cp : '0;
      cell_style     <= read_hit ? STYLE_W'(rd_st) : '0;
      touched        <= hit;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
`include "char_cell_box_draw_engine_assert.svh"

  `CBD_ASSERT_SAME(a_write_in_range, clk, rst, we_cp || we_st,
                   mem_addr_ext < CELLS_LIMIT, "canvas write beyond the memory")
  `CBD_ASSERT_SAME(a_cp_only_write, clk, rst, we_cp && !we_st,
                   mode == WM_BORDER || mode == WM_CLEAR,
                   "codepoint-only write outside border or clear")
  `CBD_ASSERT_SAME(a_read_checked, clk, rst, rd_en, hit && cmd_act == ACT_READ,
                   "memory read without an in-range read command")
  `CBD_ASSERT_NEXT(a_rsp_loaded, clk, rst, res_load, rsp_valid && state == ST_IDLE,
                   "response not presented after load")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for char_cell_box_draw_engine: directed, geometry and random traffic.
// Depends on cbd_pkg and the engine RTL; keeps its own canvas model to predict every response.
module testbench;
  import cbd_pkg::*;

  // Canvas size of the engine as instantiated (its parameter defaults).
  localparam int CANVAS_COLS  = 128;
  localparam int CANVAS_ROWS  = 64;
  localparam int CANVAS_CELLS = CANVAS_COLS * CANVAS_ROWS;
  // The fourth action code is not decoded by the engine and must leave it unchanged.
  localparam logic [ACT_W-1:0] UNUSED_ACTION = 2'd3;

  // One command transaction, as offered on the command channel.
  typedef struct {
    logic        [ACT_W-1:0]   op;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic        [FIELD_W-1:0] w;
    logic        [FIELD_W-1:0] h;
    logic                      fill;
    logic                      border;
    logic        [KIND_W-1:0]  kind;
    logic        [STYLE_W-1:0] style;
  } canvas_cmd_t;

  // One response transaction.
  typedef struct {
    logic [CP_W-1:0]    codepoint;
    logic [STYLE_W-1:0] style;
    logic               touched;
  } cell_reply_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cmd_valid;
  logic                        cmd_stall;
  logic        [ACT_W-1:0]     action;
  logic signed [FIELD_W-1:0]   rect_x;
  logic signed [FIELD_W-1:0]   rect_y;
  logic        [FIELD_W-1:0]   rect_w;
  logic        [FIELD_W-1:0]   rect_h;
  logic                        fill_enable;
  logic                        border_enable;
  logic        [KIND_W-1:0]    border_kind;
  logic        [STYLE_W-1:0]   style_word;
  logic                        rsp_valid;
  logic                        rsp_stall = 1'b0;
  logic        [CP_W-1:0]      cell_codepoint;
  logic        [STYLE_W-1:0]   cell_style;
  logic                        touched;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic        [APB_ADDR_W-1:0] paddr;
  logic        [APB_DATA_W-1:0] pwdata;
  logic        [APB_DATA_W-1:0] prdata;
  logic                        pready;

  // Shadow copy of the canvas and of the two geometry registers.
  logic [CP_W-1:0]       canvas_cp [CANVAS_CELLS];
  logic [STYLE_W-1:0]    canvas_style [CANVAS_CELLS];
  logic [COLS_REG_W-1:0] cols_reg;
  logic [ROWS_REG_W-1:0] rows_reg;

  // Responses still owed by the engine, oldest first.
  cell_reply_t expected_replies [$];
  int error_count = 0;

  // Idle rates in percent per cycle, and the length of a forced receiver hold-off.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_left = 0;

  char_cell_box_draw_engine dut (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Canvas model
  // ---------------------------------------------------------------------------

  // Register values outside the legal range saturate when the engine uses them.
  function automatic int used_columns();
    if (cols_reg == '0) return 1;
    if (int'(cols_reg) > CANVAS_COLS) return CANVAS_COLS;
    return int'(cols_reg);
  endfunction

  function automatic int used_rows();
    if (rows_reg == '0) return 1;
    if (int'(rows_reg) > CANVAS_ROWS) return CANVAS_ROWS;
    return int'(rows_reg);
  endfunction

  function automatic int clip_edge(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Box drawing glyphs, packed so that the part code selects the entry.
  function automatic logic [CP_W-1:0] box_glyph(input box_set_t glyph_set, input part_t part);
    logic [5:0][CP_W-1:0] g;
    case (glyph_set)
      SET_LIGHT:  g = {21'h2518, 21'h2514, 21'h2510, 21'h250C, 21'h2502, 21'h2500};
      SET_HEAVY:  g = {21'h255D, 21'h255A, 21'h2557, 21'h2554, 21'h2551, 21'h2550};
      SET_DASHED: g = {21'h2518, 21'h2514, 21'h2510, 21'h250C, 21'h2506, 21'h2504};
      default:    g = {21'h256F, 21'h2570, 21'h256E, 21'h256D, 21'h2502, 21'h2500};
    endcase
    return g[int'(part)];
  endfunction

  // Applies one accepted command to the shadow canvas and returns the response
  // the engine owes for it.
  function automatic cell_reply_t apply_command(input canvas_cmd_t c);
    cell_reply_t reply;
    int cols, rows, rx, ry, rw, rh, x0, x1, y0, y1, bx1, by1, i, px, py;
    box_set_t glyph_set;
    reply = '{codepoint: '0, style: '0, touched: 1'b0};
    cols = used_columns();
    rows = used_rows();
    rx = int'(c.x);
    ry = int'(c.y);
    rw = int'(c.w);
    rh = int'(c.h);
    case (c.op)
      ACT_READ: begin
        if (rx >= 0 && rx < cols && ry >= 0 && ry < rows) begin
          reply.codepoint = canvas_cp[ry * cols + rx];
          reply.style     = canvas_style[ry * cols + rx];
          reply.touched   = 1'b1;
        end
      end
      ACT_CLEAR: begin
        // Only codepoints are cleared; styles survive.
        for (i = 0; i < cols * rows; i++) canvas_cp[i] = SPACE_CP;
      end
      ACT_DRAW: begin
        x0 = clip_edge(rx, cols);
        x1 = clip_edge(rx + rw, cols);
        y0 = clip_edge(ry, rows);
        y1 = clip_edge(ry + rh, rows);
        if (x1 > x0 && y1 > y0) begin
          if (c.fill) begin
            for (py = y0; py < y1; py++) begin
              for (px = x0; px < x1; px++) begin
                canvas_cp[py * cols + px]    = SPACE_CP;
                canvas_style[py * cols + px] = c.style;
              end
            end
            reply.touched = 1'b1;
          end
          // The border needs an unclipped rectangle of at least 2x2 cells.
          bx1 = rx + rw - 1;
          by1 = ry + rh - 1;
          if (c.border && rw >= 2 && rh >= 2 && rx >= 0 && ry >= 0 &&
              bx1 < cols && by1 < rows) begin
            glyph_set = box_set_t'(c.kind[SET_W-1:0]);
            // Corners keep whatever style the cell already has.
            canvas_cp[ry * cols + rx]   = box_glyph(glyph_set, PART_TL);
            canvas_cp[ry * cols + bx1]  = box_glyph(glyph_set, PART_TR);
            canvas_cp[by1 * cols + rx]  = box_glyph(glyph_set, PART_BL);
            canvas_cp[by1 * cols + bx1] = box_glyph(glyph_set, PART_BR);
            for (px = rx + 1; px < bx1; px++) begin
              canvas_cp[ry * cols + px]     = box_glyph(glyph_set, PART_HORZ);
              canvas_style[ry * cols + px]  = c.style;
              canvas_cp[by1 * cols + px]    = box_glyph(glyph_set, PART_HORZ);
              canvas_style[by1 * cols + px] = c.style;
            end
            for (py = ry + 1; py < by1; py++) begin
              canvas_cp[py * cols + rx]     = box_glyph(glyph_set, PART_VERT);
              canvas_style[py * cols + rx]  = c.style;
              canvas_cp[py * cols + bx1]    = box_glyph(glyph_set, PART_VERT);
              canvas_style[py * cols + bx1] = c.style;
            end
            reply.touched = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic canvas_cmd_t make_cmd(input int op, input int x, input int y,
                                           input int w, input int h, input int fill,
                                           input int border, input int kind,
                                           input int style);
    canvas_cmd_t c;
    c.op     = op[ACT_W-1:0];
    c.x      = x[FIELD_W-1:0];
    c.y      = y[FIELD_W-1:0];
    c.w      = w[FIELD_W-1:0];
    c.h      = h[FIELD_W-1:0];
    c.fill   = fill[0];
    c.border = border[0];
    c.kind   = kind[KIND_W-1:0];
    c.style  = style;
    return c;
  endfunction

  // Mostly well-formed work: reads inside the canvas and small rectangles that
  // fit, so borders get drawn and then read back. The rest is rectangles that
  // hang over the edges, fully random geometry, clears and the unused action.
  function automatic canvas_cmd_t random_command();
    int cols, rows, pick, shape, op, x, y, w, h, fill, border;
    cols   = used_columns();
    rows   = used_rows();
    pick   = $urandom_range(99);
    shape  = $urandom_range(9);
    x      = $urandom_range(2047) - 1024;
    y      = $urandom_range(2047) - 1024;
    w      = $urandom_range(2047);
    h      = $urandom_range(2047);
    fill   = $urandom_range(1);
    border = $urandom_range(1);
    if (pick < 3) begin
      op = UNUSED_ACTION;
    end else if (pick < 7) begin
      op = ACT_CLEAR;
    end else if (pick < 45) begin
      op = ACT_READ;
      if (shape != 0) begin
        x = $urandom_range(cols - 1);
        y = $urandom_range(rows - 1);
      end
    end else begin
      op = ACT_DRAW;
      if (shape >= 3) begin
        w      = $urandom_range(0, (cols < 16) ? cols : 16);
        h      = $urandom_range(0, (rows < 12) ? rows : 12);
        x      = $urandom_range(0, cols - w);
        y      = $urandom_range(0, rows - h);
        border = ($urandom_range(3) != 0);
      end else if (shape >= 1) begin
        w = $urandom_range(24);
        h = $urandom_range(24);
        x = $urandom_range(cols + 16) - 8;
        y = $urandom_range(rows + 16) - 8;
      end
    end
    return make_cmd(op, x, y, w, h, fill, border, $urandom_range(255), $urandom);
  endfunction

  // Offers one command transaction, idling first at the sender's rate, and
  // records the expected response once the engine takes it.
  task automatic send_command(input canvas_cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid = 1'b0;
      @(negedge clk);
    end
    action        = c.op;
    rect_x        = c.x;
    rect_y        = c.y;
    rect_w        = c.w;
    rect_h        = c.h;
    fill_enable   = c.fill;
    border_enable = c.border;
    border_kind   = c.kind;
    style_word    = c.style;
    cmd_valid     = 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    expected_replies.push_back(apply_command(c));
  endtask

  // Stops offering commands and waits until every response has come back.
  // Every command yields a response, so the engine is idle afterwards.
  task automatic drain_results();
    @(negedge clk);
    cmd_valid = 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Writes one geometry register, updates the model and reads the register back.
  task automatic write_canvas_reg(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] readback;
    logic [APB_DATA_W-1:0] stored;
    apb_transfer(1'b1, {idx, 2'b00}, value, readback);
    if (idx == REG_COLUMNS) begin
      cols_reg = value[COLS_REG_W-1:0];
      stored   = {{(APB_DATA_W-COLS_REG_W){1'b0}}, cols_reg};
    end else begin
      rows_reg = value[ROWS_REG_W-1:0];
      stored   = {{(APB_DATA_W-ROWS_REG_W){1'b0}}, rows_reg};
    end
    apb_transfer(1'b0, {idx, 2'b00}, '0, readback);
    if (readback !== stored) begin
      $error("prdata mismatch: expected %h, actual %h", stored, readback);
      error_count++;
    end
  endtask

  task automatic set_geometry(input int cols, input int rows);
    drain_results();
    write_canvas_reg(REG_COLUMNS, cols);
    write_canvas_reg(REG_ROWS, rows);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Edge cases on the reset geometry of 80 x 24 cells.
  task automatic test_directed_cases();
    // Reads at the canvas corners and just outside it.
    send_command(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 79, 23, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 80, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 0, 24, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, -1, 5, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, -1024, 1023, 2047, 2047, 1, 1, 255, -1));
    // Extreme rectangle: clips to the whole canvas, so the border is skipped.
    send_command(make_cmd(ACT_DRAW, -1024, -1024, 2047, 2047, 1, 1, 0, 32'hFFFF_FFFF));
    // One box in each character set; a kind of 255 selects the rounded set.
    send_command(make_cmd(ACT_DRAW, 2, 2, 5, 4, 0, 1, 0, 32'hA5A5_A5A5));
    send_command(make_cmd(ACT_DRAW, 10, 2, 3, 3, 1, 1, 1, 32'h0F0F_0F0F));
    send_command(make_cmd(ACT_DRAW, 20, 5, 2, 2, 0, 1, 2, 32'h1357_9BDF));
    send_command(make_cmd(ACT_DRAW, 30, 10, 6, 5, 1, 1, 255, 32'h2468_ACE0));
    // A border along the canvas edge is still wholly inside.
    send_command(make_cmd(ACT_DRAW, 0, 0, 80, 24, 0, 1, 5, 32'h0000_0001));
    // Draws that write nothing: border hanging out, too narrow, empty area,
    // area past the canvas, and neither fill nor border.
    send_command(make_cmd(ACT_DRAW, 75, 20, 6, 4, 0, 1, 0, 32'h5555_5555));
    send_command(make_cmd(ACT_DRAW, 40, 15, 1, 5, 0, 1, 0, 32'h5555_5555));
    send_command(make_cmd(ACT_DRAW, 40, 15, 0, 5, 1, 1, 0, 32'h5555_5555));
    send_command(make_cmd(ACT_DRAW, 1023, 1023, 2047, 2047, 1, 1, 0, 32'h5555_5555));
    send_command(make_cmd(ACT_DRAW, 5, 5, 4, 4, 0, 0, 0, 32'h5555_5555));
    send_command(make_cmd(UNUSED_ACTION, 3, 3, 4, 4, 1, 1, 3, 32'hDEAD_BEEF));
    // Read back corners and sides of the boxes drawn above.
    send_command(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 79, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 3, 2, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 2, 3, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 35, 14, 0, 0, 0, 0, 0, 0));
    // A clear resets codepoints only; the styles must read back unchanged.
    send_command(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 11, 3, 0, 0, 0, 0, 0, 0));
  endtask

  // Register extremes, saturation of illegal values, and the same memory read
  // back under a different row stride.
  task automatic test_canvas_geometry();
    set_geometry(128, 64);
    send_command(make_cmd(ACT_DRAW, 0, 0, 128, 64, 1, 1, 3, 32'h1234_5678));
    send_command(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 127, 63, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 64, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 0, 32, 0, 0, 0, 0, 0, 0));
    set_geometry(1, 1);
    send_command(make_cmd(ACT_DRAW, 0, 0, 2, 2, 1, 1, 1, 32'h8000_0001));
    send_command(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 1, 0, 0, 0, 0, 0, 0, 0));
    // Zero saturates up to one column and one row.
    set_geometry(0, 0);
    send_command(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 0, 1, 0, 0, 0, 0, 0, 0));
    // All ones saturate down to the full canvas.
    set_geometry(255, 127);
    send_command(make_cmd(ACT_READ, 127, 63, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 5, 40, 0, 0, 0, 0, 0, 0));
    set_geometry(7, 3);
    send_command(make_cmd(ACT_READ, 6, 2, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_DRAW, 0, 0, 7, 3, 0, 1, 2, 32'h00FF_00FF));
    send_command(make_cmd(ACT_READ, 6, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(ACT_READ, 3, 1, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic(input int count, input int cols, input int rows,
                                     input int send_pct, input int recv_pct);
    int n;
    set_geometry(cols, rows);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (n = 0; n < count; n++) send_command(random_command());
  endtask

  // The receiver holds off for a long stretch while commands keep coming, so
  // the output register fills and the engine has to stall its input.
  task automatic test_output_backpressure();
    int n;
    set_geometry(16, 8);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left = 400;
    for (n = 0; n < 12; n++) send_command(random_command());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and response checking
  // ---------------------------------------------------------------------------

  // Drives rsp_stall: a forced hold-off when one is pending, else random stalls.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      rsp_stall = 1'b1;
      hold_off_left--;
    end else begin
      rsp_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Each response transaction is matched against the oldest expectation.
  always @(posedge clk) begin : check_replies
    cell_reply_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_replies.size() == 0) begin
        $error("response transaction with no command outstanding");
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        if (cell_codepoint !== want.codepoint) begin
          $error("cell_codepoint mismatch: expected %h, actual %h",
                 want.codepoint, cell_codepoint);
          error_count++;
        end
        if (cell_style !== want.style) begin
          $error("cell_style mismatch: expected %h, actual %h", want.style, cell_style);
          error_count++;
        end
        if (touched !== want.touched) begin
          $error("touched mismatch: expected %b, actual %b", want.touched, touched);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst           = 1'b1;
    cmd_valid     = 1'b0;
    action        = ACT_DRAW;
    rect_x        = '0;
    rect_y        = '0;
    rect_w        = '0;
    rect_h        = '0;
    fill_enable   = 1'b0;
    border_enable = 1'b0;
    border_kind   = '0;
    style_word    = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    for (int i = 0; i < CANVAS_CELLS; i++) begin
      canvas_cp[i]    = SPACE_CP;
      canvas_style[i] = '0;
    end
    cols_reg = COLS_RESET;
    rows_reg = ROWS_RESET;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // The engine sweeps its memory after reset with cmd_stall high; the first
    // command simply waits for the handshake.
    send_idle_pct = 15;
    recv_idle_pct = 78;
    test_directed_cases();
    test_canvas_geometry();
    test_random_traffic(230, 37, 11, 15, 78);
    test_random_traffic(230, 128, 64, 78, 15);
    test_random_traffic(230, $urandom_range(1, 128), $urandom_range(1, 64), 0, 0);
    test_output_backpressure();
    drain_results();

    // Leave room for any stray response transaction to show up.
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, where every command fills the
  // full canvas and every response waits out the longest stall.
  initial begin
    #300000000;
    $display("simulation failed");
    $finish;
  end

endmodule
